[rtl/kmst_pkg.sv]
// Package with the shared constants of the Kruskal spanning-tree block.
package kmst_pkg;

    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 40;
    localparam int COST_W   = 54;
    localparam int COUNT_W  = 11;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
    localparam logic [COST_W-1:0]  COST_MAX    = {COST_W{1'b1}};

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_COMP  = 3'd3;
    localparam logic [2:0] ST_SZA   = 3'd4;
    localparam logic [2:0] ST_SZB   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

endpackage

[rtl/kmst_if.sv]
// Handshake interfaces for the edge and result channels.
interface kmst_edge_if;
    import kmst_pkg::*;
    logic                valid;
    logic                ready;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] edge_weight;

    modport source (output valid, node_a, node_b, edge_weight, input ready);
    modport sink (input valid, node_a, node_b, edge_weight, output ready);
endinterface

interface kmst_result_if;
    import kmst_pkg::*;
    logic              valid;
    logic              ready;
    logic              edge_taken;
    logic [COST_W-1:0] total_cost;
    logic              tree_complete;

    modport source (output valid, edge_taken, total_cost, tree_complete, input ready);
    modport sink (input valid, edge_taken, total_cost, tree_complete, output ready);
endinterface

[rtl/kmst_tables.sv]
// Parent and set-size memories of the disjoint-set table.
module kmst_tables #(
    parameter int NW = 10,
    parameter int SW = 11
) (
    input  logic          clk,
    input  logic [NW-1:0] p_raddr,
    input  logic          p_we,
    input  logic [NW-1:0] p_waddr,
    input  logic [NW-1:0] p_wdata,
    output logic [NW-1:0] p_rdata,
    input  logic [NW-1:0] s_raddr,
    input  logic          s_we,
    input  logic [NW-1:0] s_waddr,
    input  logic [SW-1:0] s_wdata,
    output logic [SW-1:0] s_rdata
);
    localparam int DEPTH = 1 << NW;

    logic [NW-1:0] parent_mem [DEPTH];
    logic [SW-1:0] size_mem [DEPTH];
    logic [NW-1:0] p_mem_reg;
    logic [NW-1:0] p_fwd_reg;
    logic          p_hit_reg;
    logic [SW-1:0] s_mem_reg;

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            parent_mem[p_waddr] <= p_wdata;
        end
        p_mem_reg <= parent_mem[p_raddr];
        p_fwd_reg <= p_wdata;
        p_hit_reg <= p_we && (p_waddr == p_raddr);
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            size_mem[s_waddr] <= s_wdata;
        end
        s_mem_reg <= size_mem[s_raddr];
    end

    assign p_rdata = p_hit_reg ? p_fwd_reg : p_mem_reg;
    assign s_rdata = s_mem_reg;

endmodule

[rtl/kruskal_union_find_mst.sv]
// Top level of the Kruskal spanning-tree accumulator over a disjoint-set table.
// An ignored edge (tree complete or a node out of range) goes straight to the result; a
// processed edge walks to each end's root with path compression through the parent memory,
// and if the roots differ the set sizes are read and the smaller set joins the larger.
// One edge at a time: the next edge is accepted only once the last result is registered.
// After reset the tables are cleared, during which no edge is accepted.
module kruskal_union_find_mst #(
    parameter int NODES = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [kmst_pkg::COUNT_W-1:0] cfg_data,
    kmst_edge_if.sink               edges,
    kmst_result_if.source           result
);
    import kmst_pkg::*;

    localparam int NW = (NODES > 2) ? $clog2(NODES) : 1;
    localparam int SW = $clog2(NODES + 1);
    localparam int CW = ((NW > NODE_W) ? NW : NODE_W) + 1;
    localparam int KW = ((SW > COUNT_W) ? SW : COUNT_W) + 1;
    localparam logic [NW-1:0] LAST = NW'(NODES - 1);

    logic [2:0]          state_reg, state_next;
    logic [NW-1:0]       clr_reg, clr_next;
    logic [NW-1:0]       cur_reg, cur_next;
    logic [NW-1:0]       start_reg, start_next;
    logic [NW-1:0]       b_idx_reg, b_idx_next;
    logic [NW-1:0]       root_a_reg, root_a_next;
    logic [NW-1:0]       root_b_reg, root_b_next;
    logic                phase_b_reg, phase_b_next;
    logic [SW-1:0]       size_a_reg, size_a_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic                taken_reg, taken_next;
    logic [COST_W-1:0]   cost_reg, cost_next;
    logic                complete_reg, complete_next;
    logic [COUNT_W-1:0]  count_reg;
    logic                ov_reg, ov_next;
    logic                ot_reg;
    logic [COST_W-1:0]   ocost_reg;
    logic                ocomp_reg;

    logic [NW-1:0] p_raddr, p_waddr, p_wdata, p_data;
    logic          p_we;
    logic [NW-1:0] s_raddr, s_waddr;
    logic [SW-1:0] s_wdata, s_data;
    logic          s_we;

    logic [CW-1:0]     a_ext, b_ext;
    logic              a_ok, b_ok, done_now;
    logic [NW-1:0]     a_idx, b_idx, root_cur, big, small_root;
    logic [SW-1:0]     size_sum;
    logic [COST_W:0]   cost_sum;

    kmst_tables #(.NW(NW), .SW(SW)) u_tables (
        .clk     (clk),
        .p_raddr (p_raddr),
        .p_we    (p_we),
        .p_waddr (p_waddr),
        .p_wdata (p_wdata),
        .p_rdata (p_data),
        .s_raddr (s_raddr),
        .s_we    (s_we),
        .s_waddr (s_waddr),
        .s_wdata (s_wdata),
        .s_rdata (s_data)
    );

    assign a_ext    = CW'(edges.node_a);
    assign b_ext    = CW'(edges.node_b);
    assign a_ok     = a_ext < CW'(NODES);
    assign b_ok     = b_ext < CW'(NODES);
    assign a_idx    = a_ext[NW-1:0];
    assign b_idx    = b_ext[NW-1:0];
    assign done_now = complete_reg || (count_reg <= COUNT_W'(1));
    assign root_cur = phase_b_reg ? root_b_reg : root_a_reg;
    assign big        = (size_a_reg < s_data) ? root_b_reg : root_a_reg;
    assign small_root = (size_a_reg < s_data) ? root_a_reg : root_b_reg;
    assign size_sum   = size_a_reg + s_data;
    assign cost_sum   = {1'b0, cost_reg} + (COST_W + 1)'(w_reg);

    assign edges.ready          = (state_reg == ST_IDLE);
    assign result.valid         = ov_reg;
    assign result.edge_taken    = ot_reg;
    assign result.total_cost    = ocost_reg;
    assign result.tree_complete = ocomp_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cur_next      = cur_reg;
        start_next    = start_reg;
        b_idx_next    = b_idx_reg;
        root_a_next   = root_a_reg;
        root_b_next   = root_b_reg;
        phase_b_next  = phase_b_reg;
        size_a_next   = size_a_reg;
        w_next        = w_reg;
        taken_next    = taken_reg;
        cost_next     = cost_reg;
        complete_next = complete_reg;
        ov_next       = ov_reg && !result.ready;
        p_raddr = cur_reg;
        p_we    = 1'b0;
        p_waddr = cur_reg;
        p_wdata = root_cur;
        s_raddr = root_a_reg;
        s_we    = 1'b0;
        s_waddr = big;
        s_wdata = size_sum;
        unique case (state_reg)
            ST_CLEAR:
            begin
                p_we    = 1'b1;
                p_waddr = clr_reg;
                p_wdata = clr_reg;
                s_we    = 1'b1;
                s_waddr = clr_reg;
                s_wdata = SW'(1);
                if (clr_reg == LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + NW'(1);
                end
            end
            ST_IDLE:
            begin
                p_raddr = a_idx;
                if (edges.valid)
                begin
                    w_next       = edges.edge_weight;
                    cur_next     = a_idx;
                    start_next   = a_idx;
                    b_idx_next   = b_idx;
                    phase_b_next = 1'b0;
                    taken_next   = 1'b0;
                    if (done_now || !a_ok || !b_ok)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (p_data == cur_reg)
                begin
                    if (phase_b_reg)
                    begin
                        root_b_next = cur_reg;
                    end
                    else
                    begin
                        root_a_next = cur_reg;
                    end
                    cur_next   = start_reg;
                    p_raddr    = start_reg;
                    state_next = ST_COMP;
                end
                else
                begin
                    cur_next = p_data;
                    p_raddr  = p_data;
                end
            end
            ST_COMP:
            begin
                if (cur_reg == root_cur)
                begin
                    if (!phase_b_reg)
                    begin
                        phase_b_next = 1'b1;
                        cur_next     = b_idx_reg;
                        start_next   = b_idx_reg;
                        p_raddr      = b_idx_reg;
                        state_next   = ST_WALK;
                    end
                    else if (root_a_reg == root_b_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        s_raddr    = root_a_reg;
                        state_next = ST_SZA;
                    end
                end
                else
                begin
                    p_we     = 1'b1;
                    cur_next = p_data;
                    p_raddr  = p_data;
                end
            end
            ST_SZA:
            begin
                size_a_next = s_data;
                s_raddr     = root_b_reg;
                state_next  = ST_SZB;
            end
            ST_SZB:
            begin
                p_we       = 1'b1;
                p_waddr    = small_root;
                p_wdata    = big;
                s_we       = 1'b1;
                taken_next = 1'b1;
                cost_next  = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
                if (KW'(size_sum) >= KW'(count_reg))
                begin
                    complete_next = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!ov_reg || result.ready)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            cost_reg     <= '0;
            complete_reg <= 1'b0;
            count_reg    <= COUNT_RESET;
            ov_reg       <= 1'b0;
            phase_b_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            cost_reg     <= cost_next;
            complete_reg <= complete_next;
            ov_reg       <= ov_next;
            phase_b_reg  <= phase_b_next;
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        start_reg  <= start_next;
        b_idx_reg  <= b_idx_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        size_a_reg <= size_a_next;
        w_reg      <= w_next;
        taken_reg  <= taken_next;
        if (state_reg == ST_EMIT && (!ov_reg || result.ready))
        begin
            ot_reg    <= taken_reg;
            ocost_reg <= cost_reg;
            ocomp_reg <= done_now;
        end
    end

    a_complete_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        complete_reg |=> complete_reg)
        else $error("complete flag dropped");

    a_cost_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 cost_reg >= $past(cost_reg))
        else $error("total cost decreased");

    a_merge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SZB) |-> (root_a_reg != root_b_reg))
        else $error("merge of a set with itself");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !edges.ready)
        else $error("edge accepted during table clear");

endmodule

[tb/sv/tb_top.sv]
// Testbench for the Kruskal spanning-tree accumulator, with a built-in disjoint-set predictor.
`timescale 1ns / 100ps

module tb_top;
    import kmst_pkg::*;

    localparam int NODES      = 1024;
    localparam int STALL_LIMIT = 6000;
    localparam int SPAN_NODES  = 256;

    typedef struct packed {
        logic              edge_taken;
        logic [COST_W-1:0] total_cost;
        logic              tree_complete;
    } mst_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [COUNT_W-1:0] cfg_data;

    kmst_edge_if   edge_ch ();
    kmst_result_if res_ch ();

    kruskal_union_find_mst #(.NODES(NODES)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .edges    (edge_ch.sink),
        .result   (res_ch.source)
    );

    logic [NODE_W-1:0]   parent_tbl [NODES];
    logic [COUNT_W-1:0]  size_tbl [NODES];
    logic [COST_W-1:0]   cost_sum;
    logic                done_flag;
    logic [COUNT_W-1:0]  cover_count;

    mst_result_t expected_results [$];
    int  error_count;
    int  idle_cycles;
    int  burst_left;
    int  cycle_no;
    logic [WEIGHT_W-1:0] run_weight;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] n);
        logic [NODE_W-1:0] r;
        logic [NODE_W-1:0] nxt;
        r = n;
        while (parent_tbl[r] != r)
            r = parent_tbl[r];
        while (n != r)
        begin
            nxt = parent_tbl[n];
            parent_tbl[n] = r;
            n = nxt;
        end
        return r;
    endfunction

    function automatic mst_result_t join_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                              logic [WEIGHT_W-1:0] w);
        mst_result_t res;
        logic [NODE_W-1:0] ra;
        logic [NODE_W-1:0] rb;
        logic [NODE_W-1:0] big;
        logic [NODE_W-1:0] little;
        logic [COST_W:0] sum;
        res.edge_taken = 1'b0;
        if (!(done_flag || cover_count <= 1))
        begin
            ra = find_root(a);
            rb = find_root(b);
            if (ra != rb)
            begin
                big = ra;
                little = rb;
                if (size_tbl[ra] < size_tbl[rb])
                begin
                    big = rb;
                    little = ra;
                end
                parent_tbl[little] = big;
                size_tbl[big] = size_tbl[big] + size_tbl[little];
                sum = {1'b0, cost_sum} + (COST_W + 1)'(w);
                cost_sum = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
                res.edge_taken = 1'b1;
                if (size_tbl[big] >= cover_count)
                    done_flag = 1'b1;
            end
        end
        res.total_cost = cost_sum;
        res.tree_complete = done_flag || cover_count <= 1;
        return res;
    endfunction

    task automatic send_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                             logic [WEIGHT_W-1:0] w);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                edge_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        edge_ch.valid       <= 1'b1;
        edge_ch.node_a      <= a;
        edge_ch.node_b      <= b;
        edge_ch.edge_weight <= w;
        do
            @(posedge clk);
        while (!edge_ch.ready);
        expected_results = {expected_results, join_edge(a, b, w)};
        burst_left--;
    endtask

    task automatic next_weight();
        if ($urandom_range(0, 3) == 0)
            run_weight = run_weight + WEIGHT_W'($urandom_range(0, 1000000));
    endtask

    task automatic wait_idle();
        edge_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_count(logic [COUNT_W-1:0] v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cover_count = v;
        cfg_we   <= 1'b0;
    endtask

    task automatic test_single_node();
        write_count(COUNT_W'(0));
        send_edge(NODE_W'(0), NODE_W'(1023), {WEIGHT_W{1'b1}});
        send_edge(NODE_W'(1023), NODE_W'(0), WEIGHT_W'(0));
        send_edge(NODE_W'(4), NODE_W'(9), WEIGHT_W'(7));
        write_count(COUNT_W'(1));
        send_edge(NODE_W'(0), NODE_W'(1), WEIGHT_W'(1));
        send_edge(NODE_W'(1023), NODE_W'(512), {WEIGHT_W{1'b1}});
    endtask

    task automatic test_directed();
        write_count({COUNT_W{1'b1}});
        send_edge(NODE_W'(5), NODE_W'(5), WEIGHT_W'(0));
        send_edge(NODE_W'(0), NODE_W'(1023), WEIGHT_W'(0));
        send_edge(NODE_W'(1023), NODE_W'(0), WEIGHT_W'(3));
        send_edge(NODE_W'(0), NODE_W'(1), WEIGHT_W'(3));
        send_edge(NODE_W'(2), NODE_W'(3), WEIGHT_W'(10));
        send_edge(NODE_W'(3), NODE_W'(1), WEIGHT_W'(11));
        send_edge(NODE_W'(2), NODE_W'(1023), WEIGHT_W'(11));
        send_edge(NODE_W'(6), NODE_W'(7), {WEIGHT_W{1'b1}});
        send_edge(NODE_W'(7), NODE_W'(6), {WEIGHT_W{1'b1}});
        send_edge(NODE_W'(8), NODE_W'(7), {WEIGHT_W{1'b1}});
        send_edge(NODE_W'(8), NODE_W'(8), {WEIGHT_W{1'b1}});
    endtask

    task automatic test_random_forest();
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic [WEIGHT_W-1:0] w;
        for (int i = 0; i < 300; i++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                a = NODE_W'($urandom_range(0, 63));
                b = NODE_W'($urandom_range(0, 63));
            end
            else
            begin
                a = NODE_W'($urandom);
                b = NODE_W'($urandom);
            end
            next_weight();
            w = run_weight;
            if ($urandom_range(0, 9) == 0)
                w = WEIGHT_W'({$urandom, $urandom});
            send_edge(a, b, w);
        end
    endtask

    task automatic test_full_span();
        write_count(COUNT_W'(SPAN_NODES));
        for (int i = 0; i < SPAN_NODES - 1; i++)
        begin
            next_weight();
            send_edge(NODE_W'(i), NODE_W'(i + 1), run_weight);
        end
        for (int i = 0; i < 8; i++)
            send_edge(NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'({$urandom, $urandom}));
        write_count(COUNT_W'($urandom_range(2, 1024)));
        send_edge(NODE_W'(1), NODE_W'(1000), run_weight);
    endtask

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if ((cycle_no % 400) < 120)
            res_ch.ready <= 1'b1;
        else if ((cycle_no % 400) < 260)
            res_ch.ready <= ($urandom_range(0, 3) != 0);
        else
            res_ch.ready <= ($urandom_range(0, 2) == 0) || ((cycle_no % 23) < 3);
    end

    always @(posedge clk)
    begin
        mst_result_t exp_r;
        if (res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected transaction taken=%0b cost=%0d complete=%0b",
                         $time, res_ch.edge_taken, res_ch.total_cost, res_ch.tree_complete);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (res_ch.edge_taken !== exp_r.edge_taken)
                begin
                    $display("%0t: edge_taken expected %0b actual %0b",
                             $time, exp_r.edge_taken, res_ch.edge_taken);
                    error_count++;
                end
                if (res_ch.total_cost !== exp_r.total_cost)
                begin
                    $display("%0t: total_cost expected %0d actual %0d",
                             $time, exp_r.total_cost, res_ch.total_cost);
                    error_count++;
                end
                if (res_ch.tree_complete !== exp_r.tree_complete)
                begin
                    $display("%0t: tree_complete expected %0b actual %0b",
                             $time, exp_r.tree_complete, res_ch.tree_complete);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((edge_ch.valid && edge_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        edge_ch.valid = 1'b0;
        edge_ch.node_a = '0;
        edge_ch.node_b = '0;
        edge_ch.edge_weight = '0;
        res_ch.ready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        cycle_no = 0;
        run_weight = '0;
        for (int i = 0; i < NODES; i++)
        begin
            parent_tbl[i] = NODE_W'(i);
            size_tbl[i] = COUNT_W'(1);
        end
        cost_sum = '0;
        done_flag = 1'b0;
        cover_count = COUNT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_node();
        test_directed();
        test_random_forest();
        test_full_span();

        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[kruskal_union_find_mst.f]
rtl/kmst_pkg.sv
rtl/kmst_if.sv
rtl/kmst_tables.sv
rtl/kruskal_union_find_mst.sv
tb/sv/tb_top.sv
